FILE: hdl/mipmap_pkg.sv
// Shared types and constants for the 2x2 mip level downsampler.
package mipmap_pkg;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FADE_COLOR   = 2'd1,
    REG_BLEND_WEIGHT = 2'd2,
    REG_FADE_MODE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] alpha_in;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [7:0] out_alpha;
    logic       row_end;
  } out_pixel_t;

  localparam int CFG_DATA_W   = 32;
  localparam int LINE_WIDTH_W = 13;
  localparam int WEIGHT_W     = 9;
  localparam int T_W          = 18;
  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_PTR_W   = 2;
  localparam int OUTQ_CNT_W   = 3;

  localparam logic [12:0] LINE_WIDTH_RST = 13'd256;
  localparam logic [8:0]  WEIGHT_FULL    = 9'd256;

endpackage

FILE: hdl/mipmap_downsample_with_fade.sv
// Top level: 2x2 box filter mip downsampler with line store and fade blend.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_data    | one source RGBA pixel
//  output  | out_valid, out_stall, out_data | one downsampled RGBA pixel
//  config  | cfg_we, cfg_index, cfg_wdata   | one register write
//
// One pixel per cycle enters while in_stall is low; the second pixel of an
// odd-row pair is filtered (line store read, blend multiply, alpha scale).
// The line store has one write and one read port; each pixel uses at most one.
// in_stall rises only when the four-entry output queue plus in-flight results
// would fill, so out_stall reaches the input via the registered queue count.
// rst_n is synchronous; the line store is not cleared and holds garbage
// until an even row writes it.
module mipmap_downsample_with_fade
  import mipmap_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_pixel_t              in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_pixel_t             out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = SW + 1;
  localparam int EW    = CW + 1;
  localparam logic [31:0] MAXW_EVEN = 32'(MAX_WIDTH) & ~32'd1;

  // configuration
  logic [LINE_WIDTH_W-1:0] line_width_r;
  logic [31:0]             fade_color_r;
  logic [WEIGHT_W-1:0]     blend_weight_r;
  logic [1:0]              fade_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      fade_color_r   <= '0;
      blend_weight_r <= '0;
      fade_mode_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_WIDTH:   line_width_r   <= cfg_wdata[LINE_WIDTH_W-1:0];
        REG_FADE_COLOR:   fade_color_r   <= cfg_wdata;
        REG_BLEND_WEIGHT: blend_weight_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_FADE_MODE:    fade_mode_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // effective width
  logic [31:0]   lw_even;
  logic [EW-1:0] eff_w;

  always_comb begin
    lw_even = {19'd0, line_width_r[LINE_WIDTH_W-1:1], 1'b0};
    if (lw_even < 32'd2) begin
      eff_w = EW'(2);
    end else if (lw_even > MAXW_EVEN) begin
      eff_w = MAXW_EVEN[EW-1:0];
    end else begin
      eff_w = lw_even[EW-1:0];
    end
  end

  // stage 0: column tracking, pair sums, line store access
  logic [CW-1:0] col_r, col_nxt;
  logic          odd_row_r, odd_row_nxt;
  logic [31:0]   held_r, held_nxt;
  logic [CW-1:0] col_start, col;
  logic          row_start;
  logic          last_col;
  logic [SW-1:0] slot;
  logic [35:0]   pair;
  logic          accept;
  logic          store_wr;
  logic          store_rd;

  logic [35:0]   line_store [DEPTH];
  logic [35:0]   above_r;

  assign accept = in_valid && !in_stall;

  always_comb begin
    col_start = in_data.frame_start ? '0 : col_r;
    row_start = in_data.frame_start ? 1'b0 : odd_row_r;
    col       = ({1'b0, col_start} >= eff_w) ? '0 : col_start;
    last_col  = ({1'b0, col} + EW'(1)) >= eff_w;
    slot      = col[SW:1];
    pair[8:0]   = {1'b0, in_data.chan0}    + {1'b0, held_r[7:0]};
    pair[17:9]  = {1'b0, in_data.chan1}    + {1'b0, held_r[15:8]};
    pair[26:18] = {1'b0, in_data.chan2}    + {1'b0, held_r[23:16]};
    pair[35:27] = {1'b0, in_data.alpha_in} + {1'b0, held_r[31:24]};
    store_wr  = accept && col[0] && !row_start;
    store_rd  = accept && col[0] && row_start;
    held_nxt  = held_r;
    if (accept && !col[0]) begin
      held_nxt = {in_data.alpha_in, in_data.chan2, in_data.chan1, in_data.chan0};
    end
    col_nxt     = col_r;
    odd_row_nxt = odd_row_r;
    if (accept) begin
      col_nxt     = last_col ? '0 : col + CW'(1);
      odd_row_nxt = last_col ? !row_start : row_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      odd_row_r <= 1'b0;
      held_r    <= '0;
    end else begin
      col_r     <= col_nxt;
      odd_row_r <= odd_row_nxt;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      line_store[slot] <= pair;
    end
    if (store_rd) begin
      above_r <= line_store[slot];
    end
  end

  // stage 1: four-pixel sums and blend
  logic        s1_valid_r;
  logic [35:0] s1_pair_r;
  logic        s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= store_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (store_rd) begin
      s1_pair_r <= pair;
      s1_last_r <= last_col;
    end
  end

  logic [WEIGHT_W-1:0] b_sat, b_col, b_alpha;
  logic [WEIGHT_W-1:0] inv_col, inv_alpha;
  logic [9:0]          sum4   [4];
  logic [7:0]          target [4];
  logic [18:0]         blend  [4];
  logic [T_W-1:0]      t_r    [4];
  logic                s2_valid_r;
  logic                s2_last_r;

  always_comb begin
    b_sat     = (blend_weight_r > WEIGHT_FULL) ? WEIGHT_FULL : blend_weight_r;
    b_col     = fade_mode_r[0] ? b_sat : '0;
    b_alpha   = fade_mode_r[1] ? b_sat : '0;
    inv_col   = WEIGHT_FULL - b_col;
    inv_alpha = WEIGHT_FULL - b_alpha;
    target[0] = fade_color_r[23:16];
    target[1] = fade_color_r[15:8];
    target[2] = fade_color_r[7:0];
    target[3] = fade_color_r[31:24];
    for (int k = 0; k < 4; k++) begin
      sum4[k] = {1'b0, s1_pair_r[9*k +: 9]} + {1'b0, above_r[9*k +: 9]};
    end
    for (int k = 0; k < 3; k++) begin
      blend[k] = 19'(sum4[k]) * 19'(inv_col)
               + 19'({target[k], 2'b00}) * 19'(b_col);
    end
    blend[3] = 19'(sum4[3]) * 19'(inv_alpha)
             + 19'({target[3], 2'b00}) * 19'(b_alpha);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int k = 0; k < 4; k++) begin
        t_r[k] <= blend[k][T_W-1:0];
      end
      s2_last_r <= s1_last_r;
    end
  end

  // stage 2: scale, saturate and queue
  logic [21:0] alpha_x9;
  logic [8:0]  alpha_q;
  out_pixel_t  result;

  always_comb begin
    alpha_x9         = {1'b0, t_r[3], 3'b000} + 22'(t_r[3]);
    alpha_q          = alpha_x9[21:13];
    result.out_chan0 = t_r[0][17:10];
    result.out_chan1 = t_r[1][17:10];
    result.out_chan2 = t_r[2][17:10];
    result.out_alpha = (alpha_q > 9'd255) ? 8'd255 : alpha_q[7:0];
    result.row_end   = s2_last_r;
  end

  out_pixel_t            outq [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUTQ_CNT_W-1:0] occupancy;
  logic                  pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = outq[rd_ptr_r];
  assign occupancy = cnt_r + OUTQ_CNT_W'(s1_valid_r) + OUTQ_CNT_W'(s2_valid_r);
  assign in_stall  = (occupancy >= OUTQ_CNT_W'(OUTQ_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (s2_valid_r && !pop) begin
      cnt_nxt = cnt_r + OUTQ_CNT_W'(1);
    end else if (!s2_valid_r && pop) begin
      cnt_nxt = cnt_r - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s2_valid_r) begin
        wr_ptr_r <= wr_ptr_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      outq[wr_ptr_r] <= result;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("output queue overrun");

  a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(in_valid && !in_stall && col[0] && row_start))
    else $error("blend stage loaded without an odd-row transaction");

  a_s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $past(s1_valid_r))
    else $error("scale stage valid without blend stage");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    !(store_wr && store_rd))
    else $error("line store read and write in one cycle");
`endif

endmodule
